### rtl/rpplt_pkg.sv
// Shared types, codes and constants of the ping-pong link tester.
`timescale 1ns / 1ps
`default_nettype none

package rpplt_pkg;

  // Event codes
  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_BUTTON     = 3'd1;
  localparam logic [2:0] CMD_TX_DONE    = 3'd2;
  localparam logic [2:0] CMD_RX_PACKET  = 3'd3;
  localparam logic [2:0] CMD_RX_TIMEOUT = 3'd4;
  localparam logic [2:0] CMD_ABORTED    = 3'd5;
  localparam logic [2:0] CMD_CRC_ERROR  = 3'd6;
  localparam logic [2:0] CMD_OTHER      = 3'd7;

  // Radio action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_RX    = 3'd1;
  localparam logic [2:0] ACT_TX    = 3'd2;
  localparam logic [2:0] ACT_RETRY = 3'd3;
  localparam logic [2:0] ACT_ABORT = 3'd4;
  localparam logic [2:0] ACT_FAULT = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_MGR_RX_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_SUB_RX_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_MGR_GAP        = 3'd2;
  localparam logic [2:0] REG_RX_TURNAROUND  = 3'd3;
  localparam logic [2:0] REG_REPLY_DELAY    = 3'd4;
  localparam logic [2:0] REG_MAX_EXCHANGES  = 3'd5;
  localparam logic [2:0] REG_MAX_RETRIES    = 3'd6;

  localparam logic [31:0] PREFIX_PING = 32'h5049_4E47;
  localparam logic [31:0] PREFIX_PONG = 32'h504F_4E47;
  localparam logic [7:0]  FRAME_LEN   = 8'd6;

  localparam logic [15:0] RST_MGR_RX_TIMEOUT = 16'd500;
  localparam logic [15:0] RST_SUB_RX_TIMEOUT = 16'd30000;
  localparam logic [15:0] RST_MGR_GAP        = 16'd250;
  localparam logic [15:0] RST_RX_TURNAROUND  = 16'd10;
  localparam logic [15:0] RST_REPLY_DELAY    = 16'd10;
  localparam logic [7:0]  RST_MAX_EXCHANGES  = 8'd25;
  localparam logic [7:0]  RST_MAX_RETRIES    = 8'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rx_length;
    logic [31:0] rx_prefix;
    logic [7:0]  rx_separator;
    logic [7:0]  rx_counter;
    logic        abort_accepted;
  } rpplt_req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        scheduled;
    logic [15:0] delay_ms;
    logic [15:0] listen_timeout_ms;
    logic [31:0] tx_prefix;
    logic [7:0]  tx_counter;
    logic        is_manager_now;
    logic [7:0]  exchanges_now;
    logic [7:0]  fails_now;
    logic        restarted;
  } rpplt_rsp_t;

  typedef struct packed {
    logic [15:0] manager_rx_timeout_ms;
    logic [15:0] subordinate_rx_timeout_ms;
    logic [15:0] manager_gap_ms;
    logic [15:0] rx_turnaround_ms;
    logic [15:0] reply_delay_ms;
    logic [7:0]  max_exchanges;
    logic [7:0]  max_retries;
  } rpplt_cfg_t;

  typedef struct packed {
    logic       manager_role;
    logic       ping_requested;
    logic [7:0] fail_count;
    logic [7:0] exchange_count;
    logic       halted;
  } rpplt_state_t;

endpackage

`default_nettype wire

### rtl/rpplt_cfg_regs.sv
// Configuration register file of the ping-pong link tester.
`timescale 1ns / 1ps
`default_nettype none

module rpplt_cfg_regs
  import rpplt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        we_i,
  input  wire logic [2:0]  index_i,
  input  wire logic [15:0] data_i,
  output rpplt_cfg_t       cfg_o
);

  rpplt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        REG_MGR_RX_TIMEOUT: cfg_d.manager_rx_timeout_ms     = data_i;
        REG_SUB_RX_TIMEOUT: cfg_d.subordinate_rx_timeout_ms = data_i;
        REG_MGR_GAP:        cfg_d.manager_gap_ms            = data_i;
        REG_RX_TURNAROUND:  cfg_d.rx_turnaround_ms          = data_i;
        REG_REPLY_DELAY:    cfg_d.reply_delay_ms            = data_i;
        REG_MAX_EXCHANGES:  cfg_d.max_exchanges             = data_i[7:0];
        REG_MAX_RETRIES:    cfg_d.max_retries               = data_i[7:0];
        default:            cfg_d = cfg_q;  // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manager_rx_timeout_ms     <= RST_MGR_RX_TIMEOUT;
      cfg_q.subordinate_rx_timeout_ms <= RST_SUB_RX_TIMEOUT;
      cfg_q.manager_gap_ms            <= RST_MGR_GAP;
      cfg_q.rx_turnaround_ms          <= RST_RX_TURNAROUND;
      cfg_q.reply_delay_ms            <= RST_REPLY_DELAY;
      cfg_q.max_exchanges             <= RST_MAX_EXCHANGES;
      cfg_q.max_retries               <= RST_MAX_RETRIES;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/rpplt_decide.sv
// Event decision logic: next radio action and next test state for one request.
`timescale 1ns / 1ps
`default_nettype none

module rpplt_decide
  import rpplt_pkg::*;
(
  input  wire rpplt_req_t   req_i,
  input  wire rpplt_state_t state_i,
  input  wire rpplt_cfg_t   cfg_i,
  output rpplt_rsp_t        rsp_o,
  output rpplt_state_t      state_o
);

  logic [31:0] pre;
  logic [7:0]  sep;
  logic [7:0]  cnt;
  logic        len_ok;
  logic        frame_ok;
  logic [7:0]  fail_inc;
  logic [7:0]  exch_inc;
  logic [7:0]  exch_pkt;
  logic [7:0]  fail_pkt;
  rpplt_rsp_t   rsp;
  rpplt_state_t nxt;

  // A frame of the wrong length reads as all zero.
  assign len_ok   = (req_i.rx_length == FRAME_LEN);
  assign pre      = len_ok ? req_i.rx_prefix    : '0;
  assign sep      = len_ok ? req_i.rx_separator : '0;
  assign cnt      = len_ok ? req_i.rx_counter   : '0;
  assign fail_inc = state_i.fail_count + 8'd1;
  assign exch_inc = state_i.exchange_count + 8'd1;

  always_comb begin
    if (state_i.manager_role) begin
      frame_ok = len_ok && (sep == 8'd0) && (pre == PREFIX_PONG)
                 && (cnt == state_i.exchange_count);
    end else begin
      frame_ok = len_ok && (sep == 8'd0) && (pre == PREFIX_PING);
    end
  end

  assign exch_pkt = frame_ok ? exch_inc : state_i.exchange_count;
  assign fail_pkt = frame_ok ? 8'd0     : fail_inc;

  always_comb begin
    rsp = '0;
    nxt = state_i;
    if (req_i.command == CMD_START) begin
      nxt.halted         = 1'b0;
      nxt.ping_requested = 1'b0;
      nxt.manager_role   = 1'b0;
      nxt.fail_count     = '0;
      nxt.exchange_count = '0;
      rsp.restarted      = 1'b1;
      rsp.action         = ACT_RX;
      rsp.listen_timeout_ms = cfg_i.subordinate_rx_timeout_ms;
    end else if (!state_i.halted) begin
      case (req_i.command)
        CMD_BUTTON: begin
          nxt.manager_role = 1'b1;
          if (req_i.abort_accepted) begin
            nxt.ping_requested = 1'b1;
          end
          rsp.action = ACT_ABORT;
        end
        CMD_TX_DONE: begin
          rsp.action = ACT_RX;
          if (state_i.manager_role) begin
            rsp.scheduled         = 1'b1;
            rsp.delay_ms          = cfg_i.rx_turnaround_ms;
            rsp.listen_timeout_ms = cfg_i.manager_rx_timeout_ms;
          end else begin
            rsp.listen_timeout_ms = cfg_i.subordinate_rx_timeout_ms;
          end
        end
        CMD_RX_PACKET: begin
          nxt.fail_count = fail_pkt;
          if (!state_i.manager_role) begin
            // Subordinate echoes the counter it received.
            nxt.exchange_count = cnt;
            rsp.action         = ACT_TX;
            rsp.scheduled      = 1'b1;
            rsp.delay_ms       = cfg_i.reply_delay_ms;
            rsp.tx_prefix      = PREFIX_PONG;
            rsp.tx_counter     = cnt;
          end else if ((exch_pkt >= cfg_i.max_exchanges)
                       || (fail_pkt >= cfg_i.max_retries)) begin
            nxt.manager_role      = 1'b0;
            nxt.fail_count        = '0;
            nxt.exchange_count    = '0;
            rsp.restarted         = 1'b1;
            rsp.action            = ACT_RX;
            rsp.listen_timeout_ms = cfg_i.subordinate_rx_timeout_ms;
          end else begin
            nxt.exchange_count = exch_pkt;
            rsp.action         = ACT_TX;
            rsp.delay_ms       = cfg_i.manager_gap_ms;
            rsp.tx_prefix      = PREFIX_PING;
            rsp.tx_counter     = exch_pkt;
          end
        end
        CMD_RX_TIMEOUT: begin
          nxt.fail_count = fail_inc;
          if (!state_i.manager_role) begin
            rsp.action            = ACT_RX;
            rsp.listen_timeout_ms = cfg_i.subordinate_rx_timeout_ms;
          end else if (fail_inc >= cfg_i.max_retries) begin
            nxt.manager_role      = 1'b0;
            nxt.fail_count        = '0;
            nxt.exchange_count    = '0;
            rsp.restarted         = 1'b1;
            rsp.action            = ACT_RX;
            rsp.listen_timeout_ms = cfg_i.subordinate_rx_timeout_ms;
          end else begin
            rsp.action     = ACT_TX;
            rsp.delay_ms   = cfg_i.manager_gap_ms;
            rsp.tx_prefix  = PREFIX_PING;
            rsp.tx_counter = state_i.exchange_count;
          end
        end
        CMD_ABORTED: begin
          nxt.fail_count = fail_inc;
          if (state_i.ping_requested) begin
            // Abort granted after a button press: open a fresh exchange.
            nxt.ping_requested = 1'b0;
            nxt.fail_count     = '0;
            nxt.exchange_count = '0;
            rsp.action         = ACT_TX;
            rsp.tx_prefix      = state_i.manager_role ? PREFIX_PING : PREFIX_PONG;
          end else begin
            rsp.action   = ACT_RETRY;
            rsp.delay_ms = cfg_i.rx_turnaround_ms;
          end
        end
        CMD_CRC_ERROR: begin
          nxt.fail_count = fail_inc;
          rsp.action     = ACT_RETRY;
          rsp.delay_ms   = cfg_i.rx_turnaround_ms;
        end
        default: begin
          nxt.halted = 1'b1;
          rsp.action = ACT_FAULT;
        end
      endcase
    end
    rsp.is_manager_now = nxt.manager_role;
    rsp.exchanges_now  = nxt.exchange_count;
    rsp.fails_now      = nxt.fail_count;
  end

  assign rsp_o   = rsp;
  assign state_o = nxt;

endmodule

`default_nettype wire

### rtl/radio_ping_pong_link_tester_core.sv
// Top level of the ping-pong link tester: request register, decision, result register.
//
// One request is taken per clock cycle while the result side does not stall: the
// request is captured in an input register, decided in one pass of combinational
// logic against the test state and the configuration, and held in a result register
// until the consumer takes it. The test state is updated when a request moves into
// the result register, so the next request sees it at once. Back-pressure on the
// result side stalls the input register, and the input accepts a new request while
// a finished result still waits. Configuration writes are always accepted (cfg_ready_o
// is high) and take effect the next cycle; write only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module radio_ping_pong_link_tester_core
  import rpplt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire rpplt_req_t  in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rpplt_rsp_t       out_rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  rpplt_cfg_t   cfg;
  rpplt_req_t   req_q;
  logic         req_vld_q, req_vld_d;
  rpplt_rsp_t   rsp_q, rsp_d;
  logic         rsp_vld_q, rsp_vld_d;
  rpplt_state_t state_q, state_next;
  logic         advance;
  logic         in_take;

  assign cfg_ready_o = 1'b1;

  rpplt_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  rpplt_decide u_decide (
    .req_i   (req_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .rsp_o   (rsp_d),
    .state_o (state_next)
  );

  // Move the held request into the result register when that register frees up.
  assign advance    = req_vld_q && (!rsp_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign req_vld_d = in_take || (req_vld_q && !advance);
  assign rsp_vld_d = advance || (rsp_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      req_vld_q <= req_vld_d;
      rsp_vld_q <= rsp_vld_d;
      if (advance) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

### tb/sv/link_decision_checker.sv
// Checker of the ping-pong link tester: mirrors the decision logic and compares every result.
`timescale 1ns / 1ps

module link_decision_checker
  import rpplt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  rpplt_req_t  in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rpplt_rsp_t  out_rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  rpplt_state_t link;
  rpplt_cfg_t   regs;
  rpplt_rsp_t   expected_actions_q[$];
  rpplt_rsp_t   predicted;
  rpplt_rsp_t   expected;
  int           errors;

  function automatic int field_mismatch(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  task automatic listen(inout rpplt_rsp_t rsp, input logic sched, input logic [15:0] delay);
    rsp.action            = ACT_RX;
    rsp.scheduled         = sched;
    rsp.delay_ms          = delay;
    rsp.listen_timeout_ms = link.manager_role ? regs.manager_rx_timeout_ms
                                              : regs.subordinate_rx_timeout_ms;
  endtask

  task automatic transmit(inout rpplt_rsp_t rsp, input logic sched, input logic [15:0] delay);
    rsp.action     = ACT_TX;
    rsp.scheduled  = sched;
    rsp.delay_ms   = delay;
    rsp.tx_prefix  = link.manager_role ? PREFIX_PING : PREFIX_PONG;
    rsp.tx_counter = link.exchange_count;
  endtask

  task automatic retry_last(inout rpplt_rsp_t rsp);
    rsp.action    = ACT_RETRY;
    rsp.scheduled = 1'b0;
    rsp.delay_ms  = regs.rx_turnaround_ms;
  endtask

  // Drop back to subordinate with cleared counters and listen at once.
  task automatic fall_back(inout rpplt_rsp_t rsp);
    link.manager_role   = 1'b0;
    link.fail_count     = '0;
    link.exchange_count = '0;
    rsp.restarted       = 1'b1;
    listen(rsp, 1'b0, '0);
  endtask

  task automatic decide_event(input rpplt_req_t req, output rpplt_rsp_t rsp);
    logic        ok;
    logic [31:0] prefix;
    logic [7:0]  sep;
    logic [7:0]  cnt;
    rsp = '0;
    // A frame of the wrong length counts as all-zero content.
    if (req.rx_length == FRAME_LEN) begin
      prefix = req.rx_prefix;
      sep    = req.rx_separator;
      cnt    = req.rx_counter;
    end else begin
      prefix = '0;
      sep    = '0;
      cnt    = '0;
    end
    if (req.command == CMD_START) begin
      link.halted         = 1'b0;
      link.ping_requested = 1'b0;
      fall_back(rsp);
    end else if (!link.halted) begin
      case (req.command)
        CMD_BUTTON: begin
          link.manager_role = 1'b1;
          if (req.abort_accepted) link.ping_requested = 1'b1;
          rsp.action = ACT_ABORT;
        end
        CMD_TX_DONE: begin
          if (link.manager_role) listen(rsp, 1'b1, regs.rx_turnaround_ms);
          else listen(rsp, 1'b0, '0);
        end
        CMD_RX_PACKET: begin
          ok = (req.rx_length == FRAME_LEN) && (sep == 8'd0) &&
               (link.manager_role ? (prefix == PREFIX_PONG && cnt == link.exchange_count)
                                  : (prefix == PREFIX_PING));
          if (ok) begin
            link.exchange_count = link.exchange_count + 8'd1;
            link.fail_count     = '0;
          end else begin
            link.fail_count = link.fail_count + 8'd1;
          end
          if (!link.manager_role) begin
            link.exchange_count = cnt;
            transmit(rsp, 1'b1, regs.reply_delay_ms);
          end else if (link.exchange_count >= regs.max_exchanges ||
                       link.fail_count >= regs.max_retries) begin
            fall_back(rsp);
          end else begin
            transmit(rsp, 1'b0, regs.manager_gap_ms);
          end
        end
        CMD_RX_TIMEOUT: begin
          link.fail_count = link.fail_count + 8'd1;
          if (!link.manager_role) listen(rsp, 1'b0, '0);
          else if (link.fail_count >= regs.max_retries) fall_back(rsp);
          else transmit(rsp, 1'b0, regs.manager_gap_ms);
        end
        CMD_ABORTED: begin
          link.fail_count = link.fail_count + 8'd1;
          if (link.ping_requested) begin
            link.ping_requested = 1'b0;
            link.fail_count     = '0;
            link.exchange_count = '0;
            transmit(rsp, 1'b0, '0);
          end else begin
            retry_last(rsp);
          end
        end
        CMD_CRC_ERROR: begin
          link.fail_count = link.fail_count + 8'd1;
          retry_last(rsp);
        end
        default: begin
          rsp.action  = ACT_FAULT;
          link.halted = 1'b1;
        end
      endcase
    end
    rsp.is_manager_now = link.manager_role;
    rsp.exchanges_now  = link.exchange_count;
    rsp.fails_now      = link.fail_count;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link   = '0;
      regs.manager_rx_timeout_ms     = RST_MGR_RX_TIMEOUT;
      regs.subordinate_rx_timeout_ms = RST_SUB_RX_TIMEOUT;
      regs.manager_gap_ms            = RST_MGR_GAP;
      regs.rx_turnaround_ms          = RST_RX_TURNAROUND;
      regs.reply_delay_ms            = RST_REPLY_DELAY;
      regs.max_exchanges             = RST_MAX_EXCHANGES;
      regs.max_retries               = RST_MAX_RETRIES;
      expected_actions_q.delete();
      errors = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_actions_q.size() == 0) begin
          $error("result with no request outstanding: action 0x%0h", out_rsp_i.action);
          errors++;
        end else begin
          expected = expected_actions_q.pop_front();
          errors += field_mismatch("action", 32'(expected.action), 32'(out_rsp_i.action));
          errors += field_mismatch("scheduled", 32'(expected.scheduled),
                                   32'(out_rsp_i.scheduled));
          errors += field_mismatch("delay_ms", 32'(expected.delay_ms),
                                   32'(out_rsp_i.delay_ms));
          errors += field_mismatch("listen_timeout_ms", 32'(expected.listen_timeout_ms),
                                   32'(out_rsp_i.listen_timeout_ms));
          errors += field_mismatch("tx_prefix", expected.tx_prefix, out_rsp_i.tx_prefix);
          errors += field_mismatch("tx_counter", 32'(expected.tx_counter),
                                   32'(out_rsp_i.tx_counter));
          errors += field_mismatch("is_manager_now", 32'(expected.is_manager_now),
                                   32'(out_rsp_i.is_manager_now));
          errors += field_mismatch("exchanges_now", 32'(expected.exchanges_now),
                                   32'(out_rsp_i.exchanges_now));
          errors += field_mismatch("fails_now", 32'(expected.fails_now),
                                   32'(out_rsp_i.fails_now));
          errors += field_mismatch("restarted", 32'(expected.restarted),
                                   32'(out_rsp_i.restarted));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MGR_RX_TIMEOUT: regs.manager_rx_timeout_ms     = cfg_data_i;
          REG_SUB_RX_TIMEOUT: regs.subordinate_rx_timeout_ms = cfg_data_i;
          REG_MGR_GAP:        regs.manager_gap_ms            = cfg_data_i;
          REG_RX_TURNAROUND:  regs.rx_turnaround_ms          = cfg_data_i;
          REG_REPLY_DELAY:    regs.reply_delay_ms            = cfg_data_i;
          REG_MAX_EXCHANGES:  regs.max_exchanges             = cfg_data_i[7:0];
          REG_MAX_RETRIES:    regs.max_retries               = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        decide_event(in_req_i, predicted);
        expected_actions_q.push_back(predicted);
      end
      mismatch_count_o <= errors;
      outstanding_o    <= expected_actions_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// Top of the ping-pong link tester testbench: clock, reset, event and register traffic, verdict.
`timescale 1ns / 1ps

module tb;
  import rpplt_pkg::*;

  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  rpplt_req_t  in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rpplt_rsp_t  out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  int          mismatch_count;
  int          outstanding;
  int          send_idle_pct = 0;
  int          rsp_stall_pct = 0;
  int unsigned cycle_count   = 0;
  rpplt_req_t  ev;

  radio_ping_pong_link_tester_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  link_decision_checker decision_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_rsp_i        (out_rsp_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic rpplt_req_t random_event(input logic [2:0] command);
    rpplt_req_t req;
    req.command        = command;
    req.rx_length      = 8'($urandom_range(0, 255));
    req.rx_prefix      = $urandom;
    req.rx_separator   = 8'($urandom_range(0, 255));
    req.rx_counter     = 8'($urandom_range(0, 255));
    req.abort_accepted = 1'($urandom_range(0, 1));
    return req;
  endfunction

  function automatic rpplt_req_t frame(input logic [31:0] prefix, input logic [7:0] counter);
    rpplt_req_t req;
    req              = random_event(CMD_RX_PACKET);
    req.rx_length    = FRAME_LEN;
    req.rx_prefix    = prefix;
    req.rx_separator = '0;
    req.rx_counter   = counter;
    return req;
  endfunction

  function automatic rpplt_cfg_t rand_config();
    rpplt_cfg_t c;
    c.manager_rx_timeout_ms     = 16'($urandom_range(0, 65535));
    c.subordinate_rx_timeout_ms = 16'($urandom_range(0, 65535));
    c.manager_gap_ms            = 16'($urandom_range(0, 65535));
    c.rx_turnaround_ms          = 16'($urandom_range(0, 65535));
    c.reply_delay_ms            = 16'($urandom_range(0, 65535));
    c.max_exchanges             = 8'($urandom_range(1, 40));
    c.max_retries               = 8'($urandom_range(1, 12));
    return c;
  endfunction

  // Leave valid high on return; the next request or a drain decides what follows.
  task automatic send_event(input rpplt_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(input rpplt_cfg_t c);
    logic [7:0] pad_hi;
    logic [7:0] pad_lo;
    pad_hi = 8'($urandom_range(0, 255));
    pad_lo = 8'($urandom_range(0, 255));
    put_reg(REG_MGR_RX_TIMEOUT, c.manager_rx_timeout_ms);
    put_reg(REG_SUB_RX_TIMEOUT, c.subordinate_rx_timeout_ms);
    put_reg(REG_MGR_GAP, c.manager_gap_ms);
    put_reg(REG_RX_TURNAROUND, c.rx_turnaround_ms);
    put_reg(REG_REPLY_DELAY, c.reply_delay_ms);
    // Upper data bits of the byte-wide limits are don't-care.
    put_reg(REG_MAX_EXCHANGES, {pad_hi, c.max_exchanges});
    put_reg(REG_MAX_RETRIES, {pad_lo, c.max_retries});
    put_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_traffic(input int count);
    int         sent;
    int         pick;
    int         rounds;
    logic [7:0] next_cnt;
    rpplt_req_t req;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Manager session: take over, ping, and mostly answer with matching pongs.
        if ($urandom_range(0, 1) != 0) begin
          send_event(random_event(CMD_START));
          sent++;
        end
        req = random_event(CMD_BUTTON);
        req.abort_accepted = ($urandom_range(0, 9) != 0);
        send_event(req);
        send_event(random_event(CMD_ABORTED));
        sent += 2;
        next_cnt = '0;
        rounds = $urandom_range(1, 30);
        repeat (rounds) begin
          send_event(random_event(CMD_TX_DONE));
          case ($urandom_range(0, 9))
            0: send_event(random_event(CMD_RX_TIMEOUT));
            1: send_event(random_event(CMD_CRC_ERROR));
            2: send_event(random_event(CMD_RX_PACKET));
            3: send_event(frame(PREFIX_PONG, next_cnt + 8'd1));
            default: begin
              send_event(frame(PREFIX_PONG, next_cnt));
              next_cnt = next_cnt + 8'd1;
            end
          endcase
          sent += 2;
        end
      end else if (pick < 75) begin
        if ($urandom_range(0, 4) != 0) begin
          send_event(frame(PREFIX_PING, 8'($urandom_range(0, 255))));
        end else begin
          send_event(random_event(CMD_RX_PACKET));
        end
        send_event(random_event(CMD_TX_DONE));
        sent += 2;
      end else if (pick < 90) begin
        req = random_event(3'($urandom_range(0, 7)));
        send_event(req);
        sent++;
        if (req.command == CMD_OTHER && $urandom_range(0, 9) < 7) begin
          send_event(random_event(CMD_START));
          sent++;
        end
      end else begin
        send_event(random_event(CMD_START));
        sent++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 13;
    rsp_stall_pct = 63;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass with the reset register values.
    send_event(random_event(CMD_TX_DONE));
    send_event(frame(PREFIX_PING, 8'hFF));
    ev = frame(PREFIX_PING, 8'h33);
    ev.rx_length = 8'd5;
    send_event(ev);
    ev = frame(PREFIX_PING, 8'h03);
    ev.rx_separator = 8'hFF;
    send_event(ev);
    send_event(frame(PREFIX_PONG, 8'h03));
    send_event(random_event(CMD_RX_TIMEOUT));
    send_event(random_event(CMD_CRC_ERROR));
    ev = random_event(CMD_ABORTED);
    send_event(ev);
    ev = random_event(CMD_BUTTON);
    ev.abort_accepted = 1'b0;
    send_event(ev);
    ev.abort_accepted = 1'b1;
    send_event(ev);
    send_event(random_event(CMD_ABORTED));
    send_event(random_event(CMD_TX_DONE));
    send_event(frame(PREFIX_PONG, 8'h00));
    send_event(random_event(CMD_TX_DONE));
    send_event(frame(PREFIX_PONG, 8'h05));
    repeat (4) send_event(random_event(CMD_RX_TIMEOUT));
    send_event(random_event(CMD_OTHER));
    send_event(random_event(CMD_CRC_ERROR));
    send_event(random_event(CMD_START));
    ev = '1;
    ev.command = CMD_RX_PACKET;
    send_event(ev);
    send_event('0);
    drain();

    load_config(rand_config());
    run_traffic(220);
    // Hold off until every result is back, then carry on.
    drain();
    run_traffic(220);
    drain();

    send_idle_pct = 63;
    rsp_stall_pct = 13;
    load_config('1);
    run_traffic(430);
    drain();

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    load_config('0);
    // Run the failure counter past its wrap as a subordinate.
    send_event(random_event(CMD_START));
    repeat (260) send_event(random_event(CMD_CRC_ERROR));
    run_traffic(100);
    drain();
    load_config(rand_config());
    run_traffic(150);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/rpplt_pkg.sv
rtl/rpplt_cfg_regs.sv
rtl/rpplt_decide.sv
rtl/radio_ping_pong_link_tester_core.sv
tb/sv/link_decision_checker.sv
tb/sv/tb.sv
